>>> hw/rtl/ppds_pkg.sv
// Shared types, constants and the control program of the poll deadline scheduler.
package ppds_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 4;
  localparam int IVL_W = 31;
  localparam int NOW_W = 32;
  localparam int OUT_W = 32;
  localparam int CFG_W = 5;
  localparam int STEP_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_START   = 2'd1,
    CMD_SELECT  = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_t;

  // Datapath operation of one control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_RD_IDX,
    OP_LOAD,
    OP_START,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ADVANCE,
    OP_EMIT
  } uop_t;

  // Sequencing of one control word
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_WAIT_IN,
    J_DISPATCH,
    J_SCAN_MORE,
    J_DIV_MORE,
    J_WAIT_OUT
  } jcond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    uop_t   op;
    jcond_t jc;
    step_t  tgt;
  } uword_t;

  localparam step_t STEP_FETCH    = 4'd0;
  localparam step_t STEP_DISPATCH = 4'd1;
  localparam step_t STEP_LOAD     = 4'd2;
  localparam step_t STEP_START    = 4'd3;
  localparam step_t STEP_SCAN_RD  = 4'd4;
  localparam step_t STEP_SCAN_CMP = 4'd5;
  localparam step_t STEP_EMIT     = 4'd6;
  localparam step_t STEP_DIV_INIT = 4'd7;
  localparam step_t STEP_DIV      = 4'd8;
  localparam step_t STEP_ADV_WR   = 4'd9;

  // Control store
  function automatic uword_t prog(input step_t s);
    uword_t w;
    unique case (s)
      STEP_FETCH:    w = '{OP_LATCH,    J_WAIT_IN,   STEP_DISPATCH};
      STEP_DISPATCH: w = '{OP_RD_IDX,   J_DISPATCH,  STEP_FETCH};
      STEP_LOAD:     w = '{OP_LOAD,     J_GOTO,      STEP_EMIT};
      STEP_START:    w = '{OP_START,    J_GOTO,      STEP_EMIT};
      STEP_SCAN_RD:  w = '{OP_SCAN_RD,  J_NEXT,      STEP_FETCH};
      STEP_SCAN_CMP: w = '{OP_SCAN_CMP, J_SCAN_MORE, STEP_SCAN_RD};
      STEP_EMIT:     w = '{OP_EMIT,     J_WAIT_OUT,  STEP_FETCH};
      STEP_DIV_INIT: w = '{OP_DIV_INIT, J_NEXT,      STEP_FETCH};
      STEP_DIV:      w = '{OP_DIV_STEP, J_DIV_MORE,  STEP_DIV};
      STEP_ADV_WR:   w = '{OP_ADVANCE,  J_GOTO,      STEP_EMIT};
      default:       w = '{OP_NONE,     J_GOTO,      STEP_FETCH};
    endcase
    return w;
  endfunction

  // Entry step of each command
  function automatic step_t dispatch(input cmd_t c);
    step_t s;
    unique case (c)
      CMD_LOAD:    s = STEP_LOAD;
      CMD_START:   s = STEP_START;
      CMD_SELECT:  s = STEP_SCAN_RD;
      CMD_ADVANCE: s = STEP_DIV_INIT;
      default:     s = STEP_FETCH;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/ppds_in_if.sv
// Command channel: valid/ready handshake carrying one scheduler command.
interface ppds_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppds_pkg::CMD_W-1:0]    command;
  logic [ppds_pkg::IDX_W-1:0]    point_id;
  logic [ppds_pkg::IVL_W-1:0]    interval_ticks;
  logic [ppds_pkg::NOW_W-1:0]    now_tick;

  modport source (output valid, command, point_id, interval_ticks, now_tick,
                  input ready);
  modport sink   (input valid, command, point_id, interval_ticks, now_tick,
                  output ready);
endinterface

>>> hw/rtl/ppds_out_if.sv
// Result channel: valid/ready handshake carrying one scheduler result.
interface ppds_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppds_pkg::IDX_W-1:0]    selected_point;
  logic                          due;
  logic [ppds_pkg::OUT_W-1:0]    wait_ticks;
  logic [ppds_pkg::OUT_W-1:0]    deadline_value;

  modport source (output valid, selected_point, due, wait_ticks, deadline_value,
                  input ready);
  modport sink   (input valid, selected_point, due, wait_ticks, deadline_value,
                  output ready);
endinterface

>>> hw/rtl/ppds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/periodic_poll_deadline_scheduler_core.sv
// Poll deadline scheduler: each command item gives one result item. A small control
// program steps a shared datapath, one control word per cycle, holding at a wait step
// while the input or output channel is not ready. Select does one table read and one
// compare per active point; advance runs a one-bit-per-cycle remainder loop. Start
// marks every deadline entry stale by clearing its valid bit; no clearing pass runs
// after reset. A new item is taken while a finished result still waits on the output
// register.
module periodic_poll_deadline_scheduler_core #(
  parameter int MAX_POINTS = 16,
  parameter int TICK_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ppds_in_if.sink                      in_ch,
  ppds_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [ppds_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(TICK_BITS + 1);
  localparam int IW    = ppds_pkg::IVL_W;
  localparam int CW    = ppds_pkg::CFG_W;

  ppds_pkg::uword_t uw;

  ppds_pkg::step_t             pc_r, pc_nxt;
  ppds_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [ppds_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [IW-1:0]               ivl_r, ivl_nxt;
  logic [TICK_BITS-1:0]        now_r, now_nxt;
  logic [ppds_pkg::IDX_W-1:0]  sel_r, sel_nxt;
  logic [TICK_BITS-1:0]        dl_r, dl_nxt;
  logic [CW-1:0]               scan_r, scan_nxt;
  logic [IW-1:0]               step_r, step_nxt;
  logic [TICK_BITS-1:0]        shift_r, shift_nxt;
  logic [IW-1:0]               rem_r, rem_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]               active_r;
  logic [TICK_BITS-1:0]        base_r, base_nxt;
  logic [MAX_POINTS-1:0]       dvalid_r, dvalid_nxt;
  logic [MAX_POINTS-1:0]       ivalid_r, ivalid_nxt;
  logic                        rd_dval_r, rd_ival_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [ppds_pkg::IDX_W-1:0]  out_sel_r, out_sel_nxt;
  logic                        out_due_r, out_due_nxt;
  logic [ppds_pkg::OUT_W-1:0]  out_wait_r, out_wait_nxt;
  logic [ppds_pkg::OUT_W-1:0]  out_dl_r, out_dl_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic                  in_range;
  logic [AW-1:0]         idx_addr;
  logic [AW-1:0]         rd_addr;
  logic [TICK_BITS-1:0]  dram_q;
  logic [IW-1:0]         iram_q;
  logic [TICK_BITS-1:0]  rd_dl;
  logic [IW-1:0]         rd_ivl;
  logic                  dram_we;
  logic                  iram_we;
  logic [TICK_BITS-1:0]  new_dl;
  logic [IW-1:0]         ivl_wr;
  logic [TICK_BITS-1:0]  cmp_diff;
  logic                  earlier;
  logic [CW-1:0]         n_eff;
  logic                  scan_more;
  logic [IW:0]           rem_sh;
  logic [TICK_BITS-1:0]  late;
  logic [TICK_BITS-1:0]  ahead;

  assign uw        = ppds_pkg::prog(pc_r);
  assign in_ch.ready = (pc_r == ppds_pkg::STEP_FETCH);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_range  = 32'(idx_r) < MAX_POINTS;
  assign idx_addr  = AW'(idx_r);
  assign rd_addr   = (uw.op == ppds_pkg::OP_SCAN_RD) ? AW'(scan_r) : idx_addr;

  // Stale or never-written entries read as their reset or start value
  assign rd_dl  = rd_dval_r ? dram_q : base_r;
  assign rd_ivl = rd_ival_r ? iram_q : IW'(1);

  // Whole intervals past now: new deadline is now - (elapsed mod step) + step
  assign new_dl = now_r - TICK_BITS'(rem_r) + TICK_BITS'(step_r);
  assign ivl_wr = (ivl_r == '0) ? IW'(1) : ivl_r;

  assign cmp_diff = dl_r - rd_dl;
  assign earlier  = (rd_dl != dl_r) && !cmp_diff[TICK_BITS-1];

  always_comb begin
    if (active_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(active_r) > MAX_POINTS) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = active_r;
    end
  end

  assign scan_more = ({1'b0, scan_r} + (CW + 1)'(1)) < {1'b0, n_eff};
  assign rem_sh    = {rem_r, shift_r[TICK_BITS-1]};
  assign late      = now_r - dl_r;
  assign ahead     = dl_r - now_r;

  assign dram_we = (uw.op == ppds_pkg::OP_ADVANCE) && in_range;
  assign iram_we = (uw.op == ppds_pkg::OP_LOAD) && in_range;

  ppds_ram #(.WIDTH(TICK_BITS), .DEPTH(MAX_POINTS)) u_dl_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (idx_addr),
    .wdata (new_dl),
    .raddr (rd_addr),
    .rdata (dram_q)
  );

  ppds_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_ivl_ram (
    .clk   (clk),
    .we    (iram_we),
    .waddr (idx_addr),
    .wdata (ivl_wr),
    .raddr (rd_addr),
    .rdata (iram_q)
  );

  always_comb begin
    pc_nxt        = pc_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    ivl_nxt       = ivl_r;
    now_nxt       = now_r;
    sel_nxt       = sel_r;
    dl_nxt        = dl_r;
    scan_nxt      = scan_r;
    step_nxt      = step_r;
    shift_nxt     = shift_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    dvalid_nxt    = dvalid_r;
    ivalid_nxt    = ivalid_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sel_nxt   = out_sel_r;
    out_due_nxt   = out_due_r;
    out_wait_nxt  = out_wait_r;
    out_dl_nxt    = out_dl_r;

    unique case (uw.op)
      ppds_pkg::OP_LATCH: begin
        if (in_acc) begin
          cmd_nxt  = ppds_pkg::cmd_t'(in_ch.command);
          idx_nxt  = in_ch.point_id;
          ivl_nxt  = in_ch.interval_ticks;
          now_nxt  = TICK_BITS'(in_ch.now_tick);
          sel_nxt  = in_ch.point_id;
          scan_nxt = '0;
        end
      end
      ppds_pkg::OP_LOAD: begin
        dl_nxt = in_range ? rd_dl : '0;
        if (in_range) begin
          ivalid_nxt[idx_addr] = 1'b1;
        end
      end
      ppds_pkg::OP_START: begin
        base_nxt   = now_r;
        dvalid_nxt = '0;
        sel_nxt    = '0;
        dl_nxt     = now_r;
      end
      ppds_pkg::OP_SCAN_CMP: begin
        // First point seeds the minimum; ties keep the lower index
        if (scan_r == '0 || earlier) begin
          sel_nxt = ppds_pkg::IDX_W'(scan_r);
          dl_nxt  = rd_dl;
        end
        scan_nxt = scan_r + CW'(1);
      end
      ppds_pkg::OP_DIV_INIT: begin
        step_nxt  = rd_ivl;
        shift_nxt = now_r - rd_dl;
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(TICK_BITS);
      end
      ppds_pkg::OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, step_r}) begin
          rem_nxt = IW'(rem_sh - {1'b0, step_r});
        end else begin
          rem_nxt = rem_sh[IW-1:0];
        end
        shift_nxt = {shift_r[TICK_BITS-2:0], 1'b0};
        cnt_nxt   = cnt_r - CNT_W'(1);
      end
      ppds_pkg::OP_ADVANCE: begin
        dl_nxt = in_range ? new_dl : '0;
        if (in_range) begin
          dvalid_nxt[idx_addr] = 1'b1;
        end
      end
      ppds_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sel_nxt   = sel_r;
          out_due_nxt   = !late[TICK_BITS-1];
          out_wait_nxt  = late[TICK_BITS-1] ? ppds_pkg::OUT_W'(ahead) : '0;
          out_dl_nxt    = ppds_pkg::OUT_W'(dl_r);
        end
      end
      default: begin
      end
    endcase

    unique case (uw.jc)
      ppds_pkg::J_NEXT:      pc_nxt = pc_r + ppds_pkg::STEP_W'(1);
      ppds_pkg::J_GOTO:      pc_nxt = uw.tgt;
      ppds_pkg::J_WAIT_IN:   pc_nxt = in_acc ? uw.tgt : pc_r;
      ppds_pkg::J_DISPATCH:  pc_nxt = ppds_pkg::dispatch(cmd_r);
      ppds_pkg::J_SCAN_MORE: pc_nxt = scan_more ? uw.tgt : pc_r + ppds_pkg::STEP_W'(1);
      ppds_pkg::J_DIV_MORE:  pc_nxt = (cnt_r != CNT_W'(1)) ? uw.tgt
                                                           : pc_r + ppds_pkg::STEP_W'(1);
      ppds_pkg::J_WAIT_OUT:  pc_nxt = out_free ? uw.tgt : pc_r;
      default:               pc_nxt = ppds_pkg::STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ppds_pkg::STEP_FETCH;
      active_r    <= CW'(1);
      base_r      <= '0;
      dvalid_r    <= '0;
      ivalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      base_r      <= base_nxt;
      dvalid_r    <= dvalid_nxt;
      ivalid_r    <= ivalid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    ivl_r      <= ivl_nxt;
    now_r      <= now_nxt;
    sel_r      <= sel_nxt;
    dl_r       <= dl_nxt;
    scan_r     <= scan_nxt;
    step_r     <= step_nxt;
    shift_r    <= shift_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    rd_dval_r  <= dvalid_r[rd_addr];
    rd_ival_r  <= ivalid_r[rd_addr];
    out_sel_r  <= out_sel_nxt;
    out_due_r  <= out_due_nxt;
    out_wait_r <= out_wait_nxt;
    out_dl_r   <= out_dl_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.selected_point = out_sel_r;
  assign out_ch.due            = out_due_r;
  assign out_ch.wait_ticks     = out_wait_r;
  assign out_ch.deadline_value = out_dl_r;

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == ppds_pkg::STEP_EMIT)
    else $error("result raised outside the emit step");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ppds_pkg::STEP_DIV) |-> (cnt_r != '0))
    else $error("remainder loop ran past its bit count");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == ppds_pkg::OP_START) |=> (dvalid_r == '0 && dl_r == base_r))
    else $error("start left a deadline entry live");

endmodule

>>> sim/tb_periodic_poll_deadline_scheduler_core.sv
// Self-checking testbench of the poll deadline scheduler core: random and directed commands.
module tb_periodic_poll_deadline_scheduler_core;

  localparam int NOW_W       = ppds_pkg::NOW_W;
  localparam int IDX_W       = ppds_pkg::IDX_W;
  localparam int IVL_W       = ppds_pkg::IVL_W;
  localparam int OUT_W       = ppds_pkg::OUT_W;
  localparam int CFG_W       = ppds_pkg::CFG_W;
  localparam int N_POINTS    = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [NOW_W-1:0] HALF_RANGE = 32'h8000_0000;

  typedef struct {
    ppds_pkg::cmd_t   command;
    logic [IDX_W-1:0] point;
    logic [IVL_W-1:0] interval;
    logic [NOW_W-1:0] now;
  } poll_cmd_t;

  typedef struct {
    logic [IDX_W-1:0] point;
    logic             due;
    logic [OUT_W-1:0] wait_ticks;
    logic [OUT_W-1:0] deadline;
  } poll_result_t;

  // Tracks the deadline and interval tables and holds the results still owed
  class deadline_tracker;
    logic [NOW_W-1:0] deadline_tab [N_POINTS];
    logic [IVL_W-1:0] interval_tab [N_POINTS];
    logic [CFG_W-1:0] active_cfg;
    poll_result_t     pending_results [$];
    int               errors;

    function new();
      for (int i = 0; i < N_POINTS; i++) begin
        deadline_tab[i] = '0;
        interval_tab[i] = IVL_W'(1);
      end
      active_cfg = CFG_W'(1);
      errors = 0;
    endfunction

    function bit is_earlier(logic [NOW_W-1:0] a, logic [NOW_W-1:0] b);
      logic [NOW_W-1:0] gap;
      gap = b - a;
      return (a != b) && (gap < HALF_RANGE);
    endfunction

    function int scanned_points();
      if (active_cfg == 0) return 1;
      if (active_cfg > N_POINTS) return N_POINTS;
      return active_cfg;
    endfunction

    // Ties keep the lower index
    function int earliest_point();
      int sel;
      sel = 0;
      for (int i = 1; i < scanned_points(); i++)
        if (is_earlier(deadline_tab[i], deadline_tab[sel])) sel = i;
      return sel;
    endfunction

    function void note_command(poll_cmd_t c);
      poll_result_t     r;
      logic [NOW_W-1:0] dl;
      logic [NOW_W-1:0] lag;
      logic [IDX_W-1:0] sel;
      longint unsigned  elapsed;
      longint unsigned  periods;
      longint unsigned  span;
      sel = c.point;
      dl = '0;
      case (c.command)
        ppds_pkg::CMD_LOAD: begin
          interval_tab[c.point] = (c.interval == 0) ? IVL_W'(1) : c.interval;
          dl = deadline_tab[c.point];
        end
        ppds_pkg::CMD_START: begin
          for (int i = 0; i < N_POINTS; i++) deadline_tab[i] = c.now;
          sel = 0;
          dl = c.now;
        end
        ppds_pkg::CMD_SELECT: begin
          sel = IDX_W'(earliest_point());
          dl = deadline_tab[sel];
        end
        ppds_pkg::CMD_ADVANCE: begin
          lag = c.now - deadline_tab[c.point];
          elapsed = lag;
          periods = elapsed / interval_tab[c.point] + 1;
          span = deadline_tab[c.point] + periods * interval_tab[c.point];
          dl = span[NOW_W-1:0];
          deadline_tab[c.point] = dl;
        end
      endcase
      lag = c.now - dl;
      r.point = sel;
      r.deadline = dl;
      if (lag < HALF_RANGE) begin
        r.due = 1'b1;
        r.wait_ticks = '0;
      end else begin
        r.due = 1'b0;
        r.wait_ticks = dl - c.now;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(poll_result_t got);
      poll_result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result with nothing pending: point %0d deadline %h", got.point, got.deadline);
        return;
      end
      exp = pending_results.pop_front();
      if (got.point !== exp.point) begin
        errors++;
        $error("selected_point mismatch: expected %0d, got %0d", exp.point, got.point);
      end
      if (got.due !== exp.due) begin
        errors++;
        $error("due mismatch: expected %0d, got %0d", exp.due, got.due);
      end
      if (got.wait_ticks !== exp.wait_ticks) begin
        errors++;
        $error("wait_ticks mismatch: expected %h, got %h", exp.wait_ticks, got.wait_ticks);
      end
      if (got.deadline !== exp.deadline) begin
        errors++;
        $error("deadline_value mismatch: expected %h, got %h", exp.deadline, got.deadline);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  bit               idling_on = 1'b1;
  int               cycle_count = 0;
  logic [NOW_W-1:0] clock_tick = '0;

  deadline_tracker sb = new();

  ppds_in_if  in_ch();
  ppds_out_if out_ch();

  periodic_poll_deadline_scheduler_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    poll_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.point = out_ch.selected_point;
      got.due = out_ch.due;
      got.wait_ticks = out_ch.wait_ticks;
      got.deadline = out_ch.deadline_value;
      sb.check_result(got);
    end
  end

  // Result side: stall in bursts, with longer free-running stretches
  initial begin
    out_ch.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        repeat ($urandom_range(1, 32)) @(negedge clk);
      end
    end
  end

  function automatic poll_cmd_t make_cmd(ppds_pkg::cmd_t c, int p, logic [IVL_W-1:0] ivl,
                                         logic [NOW_W-1:0] t);
    poll_cmd_t pc;
    pc.command = c;
    pc.point = IDX_W'(p);
    pc.interval = ivl;
    pc.now = t;
    return pc;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with valid held
  task automatic send_cmd(poll_cmd_t c);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = c.command;
    in_ch.point_id = c.point;
    in_ch.interval_ticks = c.interval;
    in_ch.now_tick = c.now;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_active(logic [CFG_W-1:0] v);
    drain_results();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    sb.active_cfg = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [IVL_W-1:0] pick_interval();
    int r;
    logic [IVL_W-1:0] full;
    r = $urandom_range(0, 99);
    full = IVL_W'($urandom);
    if (r < 55) return IVL_W'($urandom_range(1, 300));
    if (r < 65) return '0;
    if (r < 75) return '1;
    if (r < 85) return IVL_W'($urandom_range(1, 16));
    return full;
  endfunction

  // Often near the point's deadline, sometimes on the half-range boundary, anywhere, or a rising tick
  function automatic logic [NOW_W-1:0] pick_now(int p);
    int r;
    int off;
    r = $urandom_range(0, 99);
    off = int'($urandom_range(0, 400)) - 100;
    if (r < 45) return sb.deadline_tab[p] + NOW_W'(off);
    if (r < 60) return NOW_W'($urandom);
    if (r < 70) return sb.deadline_tab[p] + 32'h7FFF_FFFE + NOW_W'($urandom_range(0, 3));
    clock_tick = clock_tick + NOW_W'($urandom_range(0, 64));
    return clock_tick;
  endfunction

  task automatic run_random_phase(int n_items);
    int sent;
    int r;
    int p;
    logic [NOW_W-1:0] t;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, N_POINTS - 1);
      if (r < 4) begin
        if ($urandom_range(0, 1) == 0) clock_tick = NOW_W'($urandom);
        send_cmd(make_cmd(ppds_pkg::CMD_START, p, pick_interval(), clock_tick));
        sent++;
      end else if (r < 16) begin
        send_cmd(make_cmd(ppds_pkg::CMD_LOAD, p, pick_interval(), pick_now(p)));
        sent++;
      end else if (r < 24) begin
        send_cmd(make_cmd(ppds_pkg::cmd_t'($urandom_range(0, 3)), p, IVL_W'($urandom),
                          NOW_W'($urandom)));
        sent++;
      end else begin
        // Poll round: pick the earliest point, then usually service it
        p = sb.earliest_point();
        t = pick_now(p);
        send_cmd(make_cmd(ppds_pkg::CMD_SELECT, $urandom_range(0, N_POINTS - 1),
                          IVL_W'($urandom), t));
        sent++;
        if ($urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 2) != 0) t = t + NOW_W'($urandom_range(0, 8));
          else t = pick_now(p);
          send_cmd(make_cmd(ppds_pkg::CMD_ADVANCE, p, IVL_W'($urandom), t));
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = ppds_pkg::CMD_LOAD;
    in_ch.point_id = '0;
    in_ch.interval_ticks = '0;
    in_ch.now_tick = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset state, zero and widest intervals, wrap of the tick count
    send_cmd(make_cmd(ppds_pkg::CMD_SELECT, 0, '0, '0));
    send_cmd(make_cmd(ppds_pkg::CMD_ADVANCE, 0, '0, '0));
    send_cmd(make_cmd(ppds_pkg::CMD_LOAD, 0, '0, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ppds_pkg::CMD_LOAD, 15, '1, 32'h8000_0000));
    send_cmd(make_cmd(ppds_pkg::CMD_LOAD, 1, 1, '0));
    send_cmd(make_cmd(ppds_pkg::CMD_LOAD, 2, 3, '0));
    send_cmd(make_cmd(ppds_pkg::CMD_START, 9, '1, 32'hFFFF_FFF0));
    send_cmd(make_cmd(ppds_pkg::CMD_ADVANCE, 15, '0, 32'hFFFF_FFF0));
    // Put point 1 exactly half the range away from point 0
    send_cmd(make_cmd(ppds_pkg::CMD_ADVANCE, 1, '0, 32'h7FFF_FFEF));
    send_cmd(make_cmd(ppds_pkg::CMD_ADVANCE, 2, '0, 32'hFFFF_FFF5));
    send_cmd(make_cmd(ppds_pkg::CMD_SELECT, 0, '0, 32'hFFFF_FFF0));
    write_active(16);
    send_cmd(make_cmd(ppds_pkg::CMD_SELECT, 15, '1, 32'hFFFF_FFF0));
    send_cmd(make_cmd(ppds_pkg::CMD_ADVANCE, 3, '0, 32'h1234_5678));
    send_cmd(make_cmd(ppds_pkg::CMD_LOAD, 3, '1, '0));
    send_cmd(make_cmd(ppds_pkg::CMD_ADVANCE, 3, '0, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ppds_pkg::CMD_SELECT, 0, '0, 32'h8000_0000));
    // Active count of zero and above the table size
    write_active(0);
    send_cmd(make_cmd(ppds_pkg::CMD_SELECT, 0, '0, '0));
    write_active(31);
    send_cmd(make_cmd(ppds_pkg::CMD_SELECT, 0, '0, 32'h7FFF_FFFF));
    write_active(17);
    send_cmd(make_cmd(ppds_pkg::CMD_START, 0, '0, '0));
    send_cmd(make_cmd(ppds_pkg::CMD_SELECT, 0, '0, '0));

    write_active(16);
    run_random_phase(130);
    write_active(1);
    run_random_phase(110);
    write_active(0);
    run_random_phase(110);
    write_active(31);
    run_random_phase(130);
    write_active(17);
    run_random_phase(110);
    write_active(CFG_W'($urandom_range(2, 15)));
    run_random_phase(140);
    write_active(8);
    run_random_phase(130);
    // Last stretch without idling on either side
    write_active(16);
    idling_on = 1'b0;
    run_random_phase(140);

    drain_results();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
